// ===== hw/rtl/lgt_pkg.sv =====
// Shared types, constants and cosine table functions for the leg gait trajectory block.
// No dependencies; every other file in hw/rtl imports this package.
`timescale 1ns / 1ps

package lgt_pkg;

   localparam int LEG_COUNT_DEF = 4;
   localparam int COS_DEPTH_DEF = 256;
   localparam int NUM_OFFSETS   = 4;

   // Divider widths: signed numerator, magnitude, unsigned divisor up to 65536
   localparam int DIV_NUM_W = 34;
   localparam int DIV_MAG_W = 33;
   localparam int DIV_DEN_W = 17;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] CSR_STRIDE = 3'd0;
   localparam logic [2:0] CSR_LIFT   = 3'd1;
   localparam logic [2:0] CSR_STANCE = 3'd2;
   localparam logic [2:0] CSR_STEP   = 3'd3;
   localparam logic [2:0] CSR_OFF0   = 3'd4;
   localparam logic [2:0] CSR_OFF1   = 3'd5;
   localparam logic [2:0] CSR_OFF2   = 3'd6;
   localparam logic [2:0] CSR_OFF3   = 3'd7;

   localparam logic [1:0] MODE_COS  = 2'd0;
   localparam logic [1:0] MODE_LIN  = 2'd1;
   localparam logic [1:0] MODE_OCOS = 2'd2;
   localparam logic [1:0] MODE_NONE = 2'd3;

   localparam logic [15:0] STANCE_RESET = 16'h8000;

   typedef struct packed {
      logic signed [15:0]              stride_length;
      logic [14:0]                     lift_height;
      logic [15:0]                     stance_fraction;
      logic [15:0]                     phase_step;
      logic [NUM_OFFSETS-1:0][15:0]    leg_offset;
   } cfg_type;

   typedef struct packed {
      logic [15:0] cycle_phase;
      logic [1:0]  gait_mode;
   } req_type;

   typedef struct packed {
      logic [1:0]         leg_index;
      logic signed [15:0] foot_x;
      logic signed [15:0] foot_z;
      logic               last_leg;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LEG, ST_ZMUL, ST_ZSTART, ST_ZDIV, ST_ZCOS,
      ST_XMUL, ST_XSTART, ST_XDIV, ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      RG_NONE, RG_STANCE, RG_SWING, RG_LIFT, RG_MOVE, RG_DROP
   } region_type;

   typedef struct packed {
      logic load_item;
      logic leg_setup;
      logic zmul;
      logic zdiv_start;
      logic zcos;
      logic xmul;
      logic xdiv_start;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
      logic last_leg;
   } sts_type;

   // Quarter-wave cosine polynomial, q in Q0.16 turns (0..16384), result Q15
   function automatic longint lgt_quarter_cos(input longint q);
      longint one;
      longint x;
      longint x2;
      longint t;
      one = 64'sd1 <<< 28;
      x   = (q * 64'sd1686629713) >>> 16;
      x2  = (x * x) >>> 28;
      t   = one - x2 / 56;
      t   = one - ((x2 * t) >>> 28) / 30;
      t   = one - ((x2 * t) >>> 28) / 12;
      t   = one - ((x2 * t) >>> 28) / 2;
      if (t < 0) begin
         t = 0;
      end
      return (t + 4096) >>> 13;
   endfunction

   // Full-turn cosine at angle t in Q0.16 turns
   function automatic longint lgt_cos_of(input longint t);
      longint c;
      if (t < 16384) begin
         c = lgt_quarter_cos(t);
      end else if (t < 32768) begin
         c = -lgt_quarter_cos(32768 - t);
      end else if (t < 49152) begin
         c = -lgt_quarter_cos(t - 32768);
      end else begin
         c = lgt_quarter_cos(65536 - t);
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/lgt_div.sv =====
// Bit-serial signed-by-unsigned divider, quotient truncated toward zero.
// One quotient bit per cycle; depends on lgt_pkg.
`timescale 1ns / 1ps

module lgt_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [lgt_pkg::DIV_NUM_W-1:0] num,
   input  logic [lgt_pkg::DIV_DEN_W-1:0]        den,
   output logic signed [lgt_pkg::DIV_NUM_W-1:0] quo,
   output logic                                done
);
   import lgt_pkg::*;

   localparam int CNT_W = $clog2(DIV_MAG_W + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_MAG_W-1:0] q_ff, q_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_mag;
   logic [DIV_DEN_W:0]   trial;
   logic                 fits;

   always_comb begin
      num_mag = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
      trial   = {rem_ff, q_ff[DIV_MAG_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = num[DIV_NUM_W-1];
         den_in  = den;
         rem_in  = '0;
         q_in    = num_mag[DIV_MAG_W-1:0];
         cnt_in  = '0;
      end else if (busy_ff) begin
         // shift in the next dividend bit, subtract when it fits
         rem_in = fits ? DIV_DEN_W'(trial - {1'b0, den_ff}) : trial[DIV_DEN_W-1:0];
         q_in   = {q_ff[DIV_MAG_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIV_MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
   end

   assign quo  = neg_ff ? -signed'({1'b0, q_ff}) : signed'({1'b0, q_ff});
   assign done = done_ff;

endmodule

// ===== hw/rtl/lgt_dp.sv =====
// Datapath: leg phase and region decode, shared multiplier, cosine table,
// divider and the result register. Depends on lgt_pkg and lgt_div.
`timescale 1ns / 1ps

module lgt_dp #(
   parameter int LEG_COUNT       = lgt_pkg::LEG_COUNT_DEF,
   parameter int COS_TABLE_DEPTH = lgt_pkg::COS_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  lgt_pkg::cfg_type cfg,
   input  lgt_pkg::req_type req_data,
   input  lgt_pkg::cmd_type cmd,
   output lgt_pkg::sts_type sts,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lgt_pkg::rsp_type rsp_data
);
   import lgt_pkg::*;

   localparam int LEG_W  = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;
   localparam int CIDX_W = $clog2(COS_TABLE_DEPTH);

   // item and per-leg registers
   logic [15:0]                 phase_ff;
   logic [1:0]                  mode_ff;
   logic [LEG_W-1:0]            leg_ff, leg_in;
   logic [LEG_COUNT-1:0]        flags_ff, flags_in;
   logic [15:0]                 p_ff;
   logic [15:0]                 u_ff;
   logic [16:0]                 r_ff;
   region_type                  region_ff;
   logic                        fs_ff;
   logic                        wrap_ff;
   logic signed [DIV_NUM_W-1:0] mul_ff;
   logic signed [17:0]          zlift_ff;
   logic signed [17:0]          qz_ff;
   logic                        out_valid_ff, out_valid_in;
   rsp_type                     out_data_ff;

   // leg setup
   logic [15:0]  off;
   logic [16:0]  sum;
   logic [17:0]  psum;
   logic         wrap;
   logic [15:0]  p;
   logic [15:0]  g;
   logic [16:0]  w;
   logic         stance;
   logic [15:0]  u;
   logic [17:0]  u3;
   logic [17:0]  w2;
   region_type   region;
   logic [16:0]  r;

   always_comb begin
      off = '0;
      for (int i = 0; i < NUM_OFFSETS; i++) begin
         if (32'(leg_ff) == i) begin
            off = cfg.leg_offset[i];
         end
      end
      sum    = {1'b0, phase_ff} + {1'b0, off};
      psum   = {1'b0, sum} + {2'b0, cfg.phase_step};
      wrap   = {1'b0, sum[16]} != psum[17:16];
      p      = sum[15:0];
      g      = cfg.stance_fraction;
      w      = 17'(17'h10000 - {1'b0, g});
      stance = p < g;
      u      = p - g;
      u3     = {1'b0, u, 1'b0} + {2'b0, u};
      w2     = {w, 1'b0};
      region = RG_NONE;
      r      = '0;
      if (mode_ff == MODE_NONE) begin
         region = RG_NONE;
      end else if (stance) begin
         region = RG_STANCE;
      end else if (mode_ff == MODE_COS) begin
         region = RG_SWING;
      end else if (u3 < {1'b0, w}) begin
         region = RG_LIFT;
         r      = u3[16:0];
      end else if (u3 < w2) begin
         region = RG_MOVE;
         r      = 17'(u3 - {1'b0, w});
      end else begin
         region = RG_DROP;
         r      = 17'(u3 - w2);
      end
   end

   // divider
   logic                        div_start;
   logic signed [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0]        div_den;
   logic signed [DIV_NUM_W-1:0] div_quo;
   logic                        div_done;

   always_comb begin
      div_num = mul_ff;
      if (cmd.zdiv_start) begin
         case (region_ff)
            RG_SWING: div_num = DIV_NUM_W'({u_ff, 16'b0});
            RG_LIFT,
            RG_DROP:  div_num = (mode_ff == MODE_LIN) ? mul_ff : DIV_NUM_W'({r_ff, 15'b0});
            default:  div_num = '0;
         endcase
      end
      div_start = cmd.zdiv_start | cmd.xdiv_start;
      div_den   = (cmd.xdiv_start && region_ff == RG_STANCE) ? {1'b0, g} : w;
   end

   lgt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (div_quo),
      .done  (div_done)
   );

   // cosine table
   logic signed [16:0] cos_tab [COS_TABLE_DEPTH];

   for (genvar k = 0; k < COS_TABLE_DEPTH; k++) begin : g_cos
      localparam longint T = (longint'(k) * 65536) / COS_TABLE_DEPTH;
      assign cos_tab[k] = 17'(lgt_cos_of(T));
   end

   logic [31:0]        cidx_full;
   logic [CIDX_W-1:0]  cidx;
   logic signed [16:0] c;
   logic signed [17:0] k_s;

   always_comb begin
      cidx_full = (32'(div_quo[15:0]) * 32'(COS_TABLE_DEPTH)) >> 16;
      cidx      = cidx_full[CIDX_W-1:0];
      c         = cos_tab[cidx];
      k_s       = (region_ff == RG_DROP) ? 18'sd32768 + 18'(c) : 18'sd32768 - 18'(c);
   end

   // shared multiplier
   logic [17:0]        m;
   logic signed [17:0] mul_a;
   logic signed [18:0] mul_b;
   logic signed [36:0] prod;
   logic [32:0]        lift_sum;

   always_comb begin
      case (region_ff)
         RG_STANCE: m = {1'b0, p_ff, 1'b0};
         RG_SWING:  m = {1'b0, u_ff, 1'b0};
         RG_MOVE:   m = fs_ff ? {1'b0, r_ff} : {r_ff, 1'b0};
         default:   m = '0;
      endcase
      if (cmd.xmul) begin
         mul_a = 18'(cfg.stride_length);
         mul_b = signed'({1'b0, m});
      end else if (cmd.zcos) begin
         mul_a = signed'({3'b0, cfg.lift_height});
         mul_b = signed'({2'b0, k_s[16:0]});
      end else begin
         mul_a = signed'({3'b0, cfg.lift_height});
         mul_b = signed'({2'b0, r_ff});
      end
      prod     = mul_a * mul_b;
      lift_sum = prod[32:0] + 33'd32768;
   end

   // result assembly
   logic signed [35:0] s_x, q_x, h_x, qz_x, zl_x, x_full, z_full;
   logic signed [15:0] x_sat, z_sat;
   logic               far_half;

   always_comb begin
      s_x      = 36'(cfg.stride_length);
      q_x      = 36'(div_quo);
      h_x      = signed'(36'(cfg.lift_height));
      qz_x     = 36'(qz_ff);
      zl_x     = 36'(zlift_ff);
      far_half = {1'b0, u_ff, 1'b0} > {1'b0, w};
      x_full   = '0;
      z_full   = '0;
      case (region_ff)
         RG_STANCE: begin
            x_full = fs_ff ? 36'sd0 : s_x - q_x;
         end
         RG_SWING: begin
            x_full = (!fs_ff || far_half) ? q_x - s_x : 36'sd0;
            z_full = zl_x;
         end
         RG_LIFT: begin
            x_full = fs_ff ? 36'sd0 : -s_x;
            z_full = (mode_ff == MODE_LIN) ? -qz_x : zl_x;
         end
         RG_MOVE: begin
            x_full = fs_ff ? q_x : q_x - s_x;
            z_full = -h_x;
         end
         RG_DROP: begin
            x_full = s_x;
            z_full = (mode_ff == MODE_LIN) ? qz_x - h_x : zl_x;
         end
         default: begin
            x_full = '0;
            z_full = '0;
         end
      endcase
      if (x_full > 36'sd32767) begin
         x_sat = 16'sd32767;
      end else if (x_full < -36'sd32767) begin
         x_sat = -16'sd32767;
      end else begin
         x_sat = x_full[15:0];
      end
      if (z_full > 36'sd32767) begin
         z_sat = 16'sd32767;
      end else if (z_full < -36'sd32767) begin
         z_sat = -16'sd32767;
      end else begin
         z_sat = z_full[15:0];
      end
   end

   // control registers
   always_comb begin
      sts.div_done = div_done;
      sts.out_free = !out_valid_ff || !rsp_stall;
      sts.last_leg = leg_ff == LEG_W'(LEG_COUNT - 1);
      leg_in       = leg_ff;
      flags_in     = flags_ff;
      out_valid_in = out_valid_ff;
      if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (cmd.load_item) begin
         leg_in = '0;
      end
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
         leg_in       = leg_ff + 1'b1;
         // drop the first-step flag once this leg's phase wraps within a step
         if (wrap_ff) begin
            flags_in[leg_ff] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leg_ff       <= '0;
         flags_ff     <= '1;
         out_valid_ff <= 1'b0;
         region_ff    <= RG_NONE;
      end else begin
         leg_ff       <= leg_in;
         flags_ff     <= flags_in;
         out_valid_ff <= out_valid_in;
         if (cmd.leg_setup) begin
            region_ff <= region;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         phase_ff <= req_data.cycle_phase;
         mode_ff  <= req_data.gait_mode;
      end
      if (cmd.leg_setup) begin
         p_ff    <= p;
         u_ff    <= u;
         r_ff    <= r;
         fs_ff   <= flags_ff[leg_ff];
         wrap_ff <= wrap;
      end
      if (cmd.zmul || cmd.xmul) begin
         mul_ff <= prod[DIV_NUM_W-1:0];
      end
      if (cmd.zcos) begin
         zlift_ff <= -signed'({1'b0, lift_sum[32:16]});
         qz_ff    <= div_quo[17:0];
      end
      if (cmd.out_load) begin
         out_data_ff.leg_index <= 2'(leg_ff);
         out_data_ff.foot_x    <= x_sat;
         out_data_ff.foot_z    <= z_sat;
         out_data_ff.last_leg  <= leg_ff == LEG_W'(LEG_COUNT - 1);
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// ===== hw/rtl/lgt_ctrl.sv =====
// Sequencer for the gait datapath: steps each leg through setup, two divides,
// the cosine lookup and the result transfer. Depends on lgt_pkg.
`timescale 1ns / 1ps

module lgt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lgt_pkg::sts_type sts,
   output lgt_pkg::cmd_type cmd
);
   import lgt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_LEG;
            end
         end
         ST_LEG: begin
            cmd.leg_setup = 1'b1;
            state_in      = ST_ZMUL;
         end
         ST_ZMUL: begin
            cmd.zmul = 1'b1;
            state_in = ST_ZSTART;
         end
         ST_ZSTART: begin
            cmd.zdiv_start = 1'b1;
            state_in       = ST_ZDIV;
         end
         ST_ZDIV: begin
            if (sts.div_done) begin
               state_in = ST_ZCOS;
            end
         end
         ST_ZCOS: begin
            cmd.zcos = 1'b1;
            state_in = ST_XMUL;
         end
         ST_XMUL: begin
            cmd.xmul = 1'b1;
            state_in = ST_XSTART;
         end
         ST_XSTART: begin
            cmd.xdiv_start = 1'b1;
            state_in       = ST_XDIV;
         end
         ST_XDIV: begin
            if (sts.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold until the result register frees up
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = sts.last_leg ? ST_IDLE : ST_LEG;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/leg_gait_trajectory.sv =====
// Leg gait trajectory generator: for each accepted gait tick (global phase and
// mode) it returns one result per leg, in leg order, with the foot x and z
// position; last_leg marks the final leg. Each leg steps through setup, the z
// multiply, the z divide, the cosine step, the x multiply, the x divide and the
// output load, where each divide has a start step and then runs the bit-serial
// divider over 33 quotient bits; a result stall holds a leg in its output load.
// A new tick is taken once the last leg's result is in the output register,
// which holds it while the next tick starts.
// Registers sit at byte addresses 4*i on the csr_ port; first-step flags are
// set by reset and cleared per leg as its phase wraps.
`timescale 1ns / 1ps

module leg_gait_trajectory #(
   parameter int LEG_COUNT       = lgt_pkg::LEG_COUNT_DEF,
   parameter int COS_TABLE_DEPTH = lgt_pkg::COS_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  lgt_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output lgt_pkg::rsp_type                rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lgt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [lgt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [lgt_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import lgt_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] csr_index;
   logic       csr_write;
   cmd_type    cmd;
   sts_type    sts;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_STRIDE: cfg_in.stride_length   = csr_pwdata[15:0];
            CSR_LIFT:   cfg_in.lift_height     = csr_pwdata[14:0];
            CSR_STANCE: cfg_in.stance_fraction = csr_pwdata[15:0];
            CSR_STEP:   cfg_in.phase_step      = csr_pwdata[15:0];
            CSR_OFF0:   cfg_in.leg_offset[0]   = csr_pwdata[15:0];
            CSR_OFF1:   cfg_in.leg_offset[1]   = csr_pwdata[15:0];
            CSR_OFF2:   cfg_in.leg_offset[2]   = csr_pwdata[15:0];
            CSR_OFF3:   cfg_in.leg_offset[3]   = csr_pwdata[15:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_STRIDE: csr_prdata = {16'b0, cfg_ff.stride_length};
         CSR_LIFT:   csr_prdata = {17'b0, cfg_ff.lift_height};
         CSR_STANCE: csr_prdata = {16'b0, cfg_ff.stance_fraction};
         CSR_STEP:   csr_prdata = {16'b0, cfg_ff.phase_step};
         CSR_OFF0:   csr_prdata = {16'b0, cfg_ff.leg_offset[0]};
         CSR_OFF1:   csr_prdata = {16'b0, cfg_ff.leg_offset[1]};
         CSR_OFF2:   csr_prdata = {16'b0, cfg_ff.leg_offset[2]};
         CSR_OFF3:   csr_prdata = {16'b0, cfg_ff.leg_offset[3]};
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{stride_length: '0, lift_height: '0, stance_fraction: STANCE_RESET,
                     phase_step: '0, leg_offset: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lgt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lgt_dp #(
      .LEG_COUNT       (LEG_COUNT),
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
